/* hw/rtl/pflru_pkg.sv */
package pflru_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int IDX_W       = $clog2(FRAME_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

    typedef struct packed {
        logic [7:0]  process_number;
        logic [15:0] page_number;
        logic [30:0] current_time;
    } t_req;

    typedef struct packed {
        logic [3:0]  frame_index;
        logic        evicted_valid;
        logic [7:0]  evicted_process;
        logic [15:0] evicted_page;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [7:0]  process_number;
        logic [15:0] page_number;
        logic [30:0] last_time;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       process_number;
        logic [15:0]      page_number;
        logic [30:0]      last_time;
    } t_wr;

endpackage

/* hw/rtl/pflru_table.sv */
module pflru_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pflru_pkg::IDX_W-1:0]  i_rd_idx,
    input  pflru_pkg::t_wr               i_wr,
    output pflru_pkg::t_entry            o_rd
);
    import pflru_pkg::*;

    logic [FRAME_COUNT-1:0] r_valid;
    logic [7:0]             r_proc [FRAME_COUNT];
    logic [15:0]            r_page [FRAME_COUNT];
    logic [30:0]            r_time [FRAME_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_proc[i_wr.idx] <= i_wr.process_number;
            r_page[i_wr.idx] <= i_wr.page_number;
            r_time[i_wr.idx] <= i_wr.last_time;
        end
    end

    always_comb begin
        o_rd.valid          = r_valid[i_rd_idx];
        o_rd.process_number = r_proc[i_rd_idx];
        o_rd.page_number    = r_page[i_rd_idx];
        o_rd.last_time      = r_time[i_rd_idx];
    end

endmodule

/* hw/rtl/page_frame_lru_replacer.sv */
// LRU page-frame replacer for a table of FRAME_COUNT (16) frames.
// Input channel (i_valid / o_ready) takes one page-fault item: process,
// page and current time. Output channel (o_valid / i_ready) returns one
// item per fault: frame used, and the evicted process and page if any.
// The frames are scanned in order by one compare unit, one frame per
// cycle. The scan stops at the first free frame; on a full table it
// visits all frames and keeps the smallest time, lowest index on a tie.
// After accept the scan runs, the chosen frame is written in S_WRITE, and
// the result is then held in S_OUT with o_valid high.
// One item is in flight at a time: o_ready is high only when idle, so a
// new fault is accepted only after the result of the last one is taken.
// The result is held in an output register until i_ready; while the
// receiver stalls the block accepts nothing.
// Reset (synchronous, active low) marks every frame free and drops any
// item in progress; the block is ready on the next cycle.
module page_frame_lru_replacer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pflru_pkg::t_req i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output pflru_pkg::t_rsp o_item
);
    import pflru_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_best, n_best;
    logic [30:0]      r_best_time, n_best_time;
    logic [7:0]       r_best_proc, n_best_proc;
    logic [15:0]      r_best_page, n_best_page;
    logic             r_evict, n_evict;
    t_req             r_req;
    t_rsp             r_rsp, n_rsp;

    t_entry rd;
    t_wr    wr;
    logic   take_new;

    pflru_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .i_wr     (wr),
        .o_rd     (rd)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_rsp;

    assign take_new = (r_idx == '0) || (rd.last_time < r_best_time);

    always_comb begin
        wr.en             = (r_state == S_WRITE);
        wr.idx            = r_best;
        wr.process_number = r_req.process_number;
        wr.page_number    = r_req.page_number;
        wr.last_time      = r_req.current_time;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_time = r_best_time;
        n_best_proc = r_best_proc;
        n_best_page = r_best_page;
        n_evict     = r_evict;
        n_rsp       = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd.valid) begin
                    n_best  = r_idx;
                    n_evict = 1'b0;
                    n_state = S_WRITE;
                end else begin
                    n_evict = 1'b1;
                    if (take_new) begin
                        n_best      = r_idx;
                        n_best_time = rd.last_time;
                        n_best_proc = rd.process_number;
                        n_best_page = rd.page_number;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_WRITE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_WRITE: begin
                n_rsp.frame_index     = 4'(r_best);
                n_rsp.evicted_valid   = r_evict;
                n_rsp.evicted_process = r_evict ? r_best_proc : 8'd0;
                n_rsp.evicted_page    = r_evict ? r_best_page : 16'd0;
                n_state               = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best      <= n_best;
        r_best_time <= n_best_time;
        r_best_proc <= n_best_proc;
        r_best_page <= n_best_page;
        r_evict     <= n_evict;
        r_rsp       <= n_rsp;
        if (i_valid && o_ready) begin
            r_req <= i_item;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and result valid together");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("scan did not start at frame zero");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && $past(r_state) == S_SCAN)
        |-> (r_idx == $past(r_idx) + 1'b1))
        else $error("scan index skipped a frame");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.evicted_valid)
        |-> (o_item.evicted_process == 8'd0 && o_item.evicted_page == 16'd0))
        else $error("evicted fields set without eviction");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_OUT))
        else $error("write not followed by result");

endmodule
